@@ hw/rtl/assert_macros.svh @@
// Assertion macros used by the top-level RTL module of the line-ending converter.
// Needs a clock named clk and an active-low reset named rst_n in the using module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks a property on every rising clock edge outside reset.
`define TLEC_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Checks a property on every rising clock edge, reset included.
`define TLEC_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

@@ hw/rtl/tlec_pkg.sv @@
// Package for the text line-ending converter: payload structs, scanner state
// and character constants. No dependencies.
package tlec_pkg;

  localparam logic [1:0] MODE_LF_TO_CRLF = 2'd0;
  localparam logic [1:0] MODE_CRLF_TO_LF = 2'd1;
  localparam logic [1:0] MODE_GBK        = 2'd2;

  localparam logic [7:0] CH_CR        = 8'h0D;
  localparam logic [7:0] CH_LF        = 8'h0A;
  localparam logic [7:0] GBK_LEAD_LO  = 8'h81;
  localparam logic [7:0] GBK_LEAD_HI  = 8'hFE;
  localparam logic [7:0] GBK_DIGIT_LO = 8'h30;
  localparam logic [7:0] GBK_DIGIT_HI = 8'h39;
  localparam logic [7:0] GBK_SPACE    = 8'hA1;

  localparam int LINES_W = 32;

  localparam logic [1:0] GBK_FIRST = 2'd0;
  localparam logic [1:0] GBK_LEAD  = 2'd1;
  localparam logic [1:0] GBK_REM2  = 2'd2;
  localparam logic [1:0] GBK_REM1  = 2'd3;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       end_of_stream;
  } tlec_in_t;

  typedef struct packed {
    logic [7:0]         out_byte;
    logic               out_last;
    logic [LINES_W-1:0] lines_in;
    logic [LINES_W-1:0] lines_changed;
    logic [LINES_W-1:0] lines_out;
  } tlec_out_t;

  typedef struct packed {
    logic       held_valid;
    logic [7:0] held_value;
    logic       prev_was_cr;
    logic [1:0] gbk_phase;
    logic       line_touched;
    logic       line_has_bytes;
  } tlec_state_t;

  // Bytes produced by one request and the counter increments it causes.
  typedef struct packed {
    logic [1:0] n_out;
    logic [7:0] byte0;
    logic [7:0] byte1;
    logic       inc_in;
    logic       inc_changed;
    logic [1:0] inc_out;
  } tlec_step_t;

endpackage

@@ hw/rtl/tlec_step.sv @@
// Combinational byte step of the line-ending converter: next scanner state,
// up to two output bytes and counter increments. Depends on tlec_pkg.
module tlec_step (
  input  logic [1:0]           mode,
  input  tlec_pkg::tlec_state_t st,
  input  tlec_pkg::tlec_in_t   in_data,
  output tlec_pkg::tlec_state_t st_nxt,
  output tlec_pkg::tlec_step_t res
);
  import tlec_pkg::*;

  tlec_state_t s;
  tlec_step_t  r;
  logic [7:0]  b;
  logic [7:0]  lead;
  logic        done;

  function automatic tlec_step_t put_byte(tlec_step_t p, logic [7:0] v);
    tlec_step_t q;
    q = p;
    if (q.n_out == 2'd0) begin
      q.byte0 = v;
    end else if (q.n_out == 2'd1) begin
      q.byte1 = v;
    end
    if (q.n_out != 2'd2) begin
      q.n_out = q.n_out + 2'd1;
    end
    return q;
  endfunction

  function automatic tlec_step_t count_line(tlec_step_t p, logic touched);
    tlec_step_t q;
    q = p;
    q.inc_in  = 1'b1;
    q.inc_out = q.inc_out + 2'd1;
    if (touched) begin
      q.inc_changed = 1'b1;
    end
    return q;
  endfunction

  function automatic tlec_state_t clear_line(tlec_state_t p);
    tlec_state_t q;
    q = p;
    q.line_touched   = 1'b0;
    q.line_has_bytes = 1'b0;
    q.prev_was_cr    = 1'b0;
    q.gbk_phase      = GBK_FIRST;
    q.held_valid     = 1'b0;
    return q;
  endfunction

  always_comb begin
    s    = st;
    r    = '0;
    b    = in_data.in_byte;
    lead = st.held_value;
    done = 1'b0;
    unique case (mode)
      MODE_CRLF_TO_LF: begin
        // A held CR is resolved by the byte that follows it.
        if (s.held_valid) begin
          s.held_valid = 1'b0;
          if (b == CH_LF) begin
            r = put_byte(r, CH_LF);
            s.line_touched = 1'b1;
            r = count_line(r, s.line_touched);
            s = clear_line(s);
            done = 1'b1;
          end else begin
            r = put_byte(r, CH_CR);
          end
        end
        if (!done) begin
          if (b == CH_CR) begin
            s.held_valid     = 1'b1;
            s.held_value     = CH_CR;
            s.line_has_bytes = 1'b1;
          end else if (b == CH_LF) begin
            r = put_byte(r, CH_LF);
            r = count_line(r, s.line_touched);
            s = clear_line(s);
          end else begin
            r = put_byte(r, b);
            s.line_has_bytes = 1'b1;
          end
        end
      end
      MODE_GBK: begin
        if (b == CH_LF) begin
          if (s.held_valid) begin
            r = put_byte(r, s.held_value);
          end
          r = put_byte(r, CH_LF);
          r = count_line(r, s.line_touched);
          s = clear_line(s);
        end else begin
          s.line_has_bytes = 1'b1;
          case (s.gbk_phase)
            GBK_LEAD: begin
              s.held_valid = 1'b0;
              if (b >= GBK_DIGIT_LO && b <= GBK_DIGIT_HI) begin
                r = put_byte(r, lead);
                r = put_byte(r, b);
                s.gbk_phase = GBK_REM2;
              end else if (lead == GBK_SPACE && b == GBK_SPACE) begin
                // Full-width space becomes a line break.
                r = put_byte(r, CH_CR);
                r = put_byte(r, CH_LF);
                r.inc_out = r.inc_out + 2'd1;
                s.line_touched = 1'b1;
                s.gbk_phase = GBK_FIRST;
              end else begin
                r = put_byte(r, lead);
                r = put_byte(r, b);
                s.gbk_phase = GBK_FIRST;
              end
            end
            GBK_REM2: begin
              r = put_byte(r, b);
              s.gbk_phase = GBK_REM1;
            end
            GBK_REM1: begin
              r = put_byte(r, b);
              s.gbk_phase = GBK_FIRST;
            end
            default: begin
              if (b >= GBK_LEAD_LO && b <= GBK_LEAD_HI) begin
                s.held_valid = 1'b1;
                s.held_value = b;
                s.gbk_phase  = GBK_LEAD;
              end else begin
                r = put_byte(r, b);
              end
            end
          endcase
        end
      end
      default: begin
        // LF to CR LF; the unused mode code behaves the same way.
        if (b == CH_LF) begin
          if (!s.prev_was_cr) begin
            r = put_byte(r, CH_CR);
            s.line_touched = 1'b1;
          end
          r = put_byte(r, CH_LF);
          r = count_line(r, s.line_touched);
          s = clear_line(s);
        end else begin
          r = put_byte(r, b);
          s.prev_was_cr    = (b == CH_CR);
          s.line_has_bytes = 1'b1;
        end
      end
    endcase

    if (in_data.end_of_stream) begin
      if (s.held_valid) begin
        r = put_byte(r, s.held_value);
      end
      if (s.line_has_bytes) begin
        r = count_line(r, s.line_touched);
      end
      s = clear_line(s);
    end

    st_nxt = s;
    res    = r;
  end

endmodule

@@ hw/rtl/text_line_ending_converter.sv @@
// Top level of the text line-ending converter: state, counters and a two-entry
// result register. Depends on tlec_pkg, tlec_step and assert_macros.svh.
//
//   Channel | Ports                          | Moves
//   --------+--------------------------------+------------------------------------
//   in      | in_valid, in_stall, in_data    | one source byte and end-of-stream
//   out     | out_valid, out_stall, out_data | one output byte with line counters
//   cfg     | cfg_we, cfg_data               | conversion mode
//
// A byte is converted in the cycle it is accepted; its results appear on the
// next cycle. One request per cycle when each byte yields at most one result
// and the output is not stalled; a byte that yields two holds the input while
// the two-entry result register drains. Reset is synchronous.
// A stalled output stops the input once the result register cannot empty.
`include "assert_macros.svh"

module text_line_ending_converter #(
  parameter int COUNT_WIDTH = 32
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  tlec_pkg::tlec_in_t  in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output tlec_pkg::tlec_out_t out_data,
  input  logic                cfg_we,
  input  logic [1:0]          cfg_data
);
  import tlec_pkg::*;

  localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = {COUNT_WIDTH{1'b1}};

  logic [1:0]             mode_r;
  tlec_state_t            state_r, state_nxt, step_state;
  tlec_step_t             step_res;
  logic [COUNT_WIDTH-1:0] count_in_r, count_in_nxt;
  logic [COUNT_WIDTH-1:0] count_changed_r, count_changed_nxt;
  logic [COUNT_WIDTH-1:0] count_out_r, count_out_nxt;
  logic [1:0]             ob_cnt_r, ob_cnt_nxt;
  logic [7:0]             ob_byte0_r, ob_byte0_nxt;
  logic [7:0]             ob_byte1_r, ob_byte1_nxt;
  logic                   in_acc;
  logic                   out_pop;

  function automatic logic [COUNT_WIDTH-1:0] sat_add(logic [COUNT_WIDTH-1:0] v,
                                                     logic [1:0] amt);
    logic [COUNT_WIDTH:0] sum;
    sum = {1'b0, v} + (COUNT_WIDTH+1)'(amt);
    return sum[COUNT_WIDTH] ? COUNT_MAX : sum[COUNT_WIDTH-1:0];
  endfunction

  tlec_step u_step (
    .mode    (mode_r),
    .st      (state_r),
    .in_data (in_data),
    .st_nxt  (step_state),
    .res     (step_res)
  );

  assign out_pop  = out_valid && !out_stall;
  // Take a new request only when the result register is empty by the next edge.
  assign in_stall = (ob_cnt_r == 2'd2) || ((ob_cnt_r == 2'd1) && out_stall);
  assign in_acc   = in_valid && !in_stall;

  always_comb begin
    state_nxt         = state_r;
    count_in_nxt      = count_in_r;
    count_changed_nxt = count_changed_r;
    count_out_nxt     = count_out_r;
    ob_cnt_nxt        = ob_cnt_r;
    ob_byte0_nxt      = ob_byte0_r;
    ob_byte1_nxt      = ob_byte1_r;
    if (cfg_we) begin
      state_nxt.held_valid  = 1'b0;
      state_nxt.prev_was_cr = 1'b0;
      state_nxt.gbk_phase   = GBK_FIRST;
    end else if (in_acc) begin
      state_nxt         = step_state;
      count_in_nxt      = sat_add(count_in_r, {1'b0, step_res.inc_in});
      count_changed_nxt = sat_add(count_changed_r, {1'b0, step_res.inc_changed});
      count_out_nxt     = sat_add(count_out_r, step_res.inc_out);
    end
    if (in_acc) begin
      ob_cnt_nxt   = step_res.n_out;
      ob_byte0_nxt = step_res.byte0;
      ob_byte1_nxt = step_res.byte1;
    end else if (out_pop) begin
      ob_cnt_nxt   = ob_cnt_r - 2'd1;
      ob_byte0_nxt = ob_byte1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r          <= MODE_LF_TO_CRLF;
      state_r         <= '0;
      count_in_r      <= '0;
      count_changed_r <= '0;
      count_out_r     <= '0;
      ob_cnt_r        <= 2'd0;
    end else begin
      if (cfg_we) begin
        mode_r <= cfg_data;
      end
      state_r         <= state_nxt;
      count_in_r      <= count_in_nxt;
      count_changed_r <= count_changed_nxt;
      count_out_r     <= count_out_nxt;
      ob_cnt_r        <= ob_cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    ob_byte0_r <= ob_byte0_nxt;
    ob_byte1_r <= ob_byte1_nxt;
  end

  // The counters only change on an accepted request, which needs a result register that
  // is empty or is sending its last entry, so the live counters belong to the bytes still waiting.
  assign out_valid              = (ob_cnt_r != 2'd0);
  assign out_data.out_byte      = ob_byte0_r;
  assign out_data.out_last      = (ob_cnt_r == 2'd1);
  assign out_data.lines_in      = LINES_W'(count_in_r);
  assign out_data.lines_changed = LINES_W'(count_changed_r);
  assign out_data.lines_out     = LINES_W'(count_out_r);

  `TLEC_ASSERT(a_acc_drained, in_acc |-> (ob_cnt_r == 2'd0 || (ob_cnt_r == 2'd1 && out_pop)), "request accepted while results still pending")
  `TLEC_ASSERT(a_pair_follows, (out_pop && !out_data.out_last) |=> out_valid, "second result of a request went missing")
  `TLEC_ASSERT(a_hold_mode, state_r.held_valid |-> (mode_r == MODE_CRLF_TO_LF || mode_r == MODE_GBK), "byte held in a mode that never holds")
  `TLEC_ASSERT(a_gbk_phase, (state_r.gbk_phase != GBK_FIRST) |-> (mode_r == MODE_GBK), "GBK scanner active outside GBK mode")
  `TLEC_ASSERT(a_cnt_range, ob_cnt_r != 2'd3, "result register holds more than two entries")
  `TLEC_ASSERT_ALWAYS(a_reset_idle, !rst_n |=> !out_valid, "result offered right after reset")

endmodule

@@ test/tb.sv @@
// Testbench for text_line_ending_converter: directed requests, then random text streams
// in every mode, checked against a behavioral model of the conversion; typed rows give their own bytes.
// Depends on tlec_pkg and the RTL of the converter.
module tb;
  import tlec_pkg::*;

  localparam logic [1:0] MODE_UNDEFINED = 2'd3;
  localparam int PHASE_ITEMS = 240;
  localparam int LONG_HOLD_AT = 600;
  localparam int LONG_HOLD_CYCLES = 80;

  logic       clk;
  logic       rst_n;
  logic       in_valid;
  logic       in_stall;
  tlec_in_t   in_data;
  logic       out_valid;
  logic       out_stall;
  tlec_out_t  out_data;
  logic       cfg_we;
  logic [1:0] cfg_data;

  text_line_ending_converter #(.COUNT_WIDTH(32)) DUT (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data),
    .cfg_we   (cfg_we),
    .cfg_data (cfg_data)
  );

  // Model of the converter: mode, scanner state and line counters.
  logic [1:0]  cur_mode;
  logic        held_v;
  logic [7:0]  held_b;
  logic        after_cr;
  logic [1:0]  scan_phase;
  logic        touched;
  logic        has_bytes;
  logic [31:0] n_in;
  logic [31:0] n_changed;
  logic [31:0] n_out;
  logic [7:0]  step_bytes[$];

  tlec_out_t   expected_text[$];
  logic [7:0]  text_q[$];
  int          errors;
  int          requests_sent;
  int          results_seen;
  bit          calm;

  typedef struct packed {
    logic [1:0] mode;
    logic [7:0] data;
    logic       eos;
    logic       typed;
    logic [1:0] n;
    logic [7:0] e0;
    logic [7:0] e1;
  } text_row_t;

  // Rows with typed set carry their output bytes; the others use the model.
  text_row_t directed_rows [26] = '{
    '{MODE_LF_TO_CRLF, 8'h41,  1'b0, 1'b1, 2'd1, 8'h41,  8'h00},
    '{MODE_LF_TO_CRLF, CH_LF,  1'b0, 1'b1, 2'd2, CH_CR,  CH_LF},
    '{MODE_LF_TO_CRLF, CH_CR,  1'b0, 1'b0, 2'd0, 8'h00,  8'h00},
    '{MODE_LF_TO_CRLF, CH_LF,  1'b0, 1'b0, 2'd0, 8'h00,  8'h00},
    '{MODE_LF_TO_CRLF, 8'h00,  1'b0, 1'b1, 2'd1, 8'h00,  8'h00},
    '{MODE_LF_TO_CRLF, 8'hFF,  1'b0, 1'b1, 2'd1, 8'hFF,  8'h00},
    '{MODE_LF_TO_CRLF, 8'h41,  1'b1, 1'b0, 2'd0, 8'h00,  8'h00},
    '{MODE_CRLF_TO_LF, CH_CR,  1'b0, 1'b1, 2'd0, 8'h00,  8'h00},
    '{MODE_CRLF_TO_LF, CH_LF,  1'b0, 1'b1, 2'd1, CH_LF,  8'h00},
    '{MODE_CRLF_TO_LF, CH_CR,  1'b0, 1'b0, 2'd0, 8'h00,  8'h00},
    '{MODE_CRLF_TO_LF, 8'h41,  1'b0, 1'b0, 2'd0, 8'h00,  8'h00},
    '{MODE_CRLF_TO_LF, CH_CR,  1'b1, 1'b0, 2'd0, 8'h00,  8'h00},
    '{MODE_GBK,        8'hA1,  1'b0, 1'b1, 2'd0, 8'h00,  8'h00},
    '{MODE_GBK,        8'hA1,  1'b0, 1'b1, 2'd2, CH_CR,  CH_LF},
    '{MODE_GBK,        8'h81,  1'b0, 1'b0, 2'd0, 8'h00,  8'h00},
    '{MODE_GBK,        8'h30,  1'b0, 1'b0, 2'd0, 8'h00,  8'h00},
    '{MODE_GBK,        8'h81,  1'b0, 1'b0, 2'd0, 8'h00,  8'h00},
    '{MODE_GBK,        8'h39,  1'b0, 1'b0, 2'd0, 8'h00,  8'h00},
    '{MODE_GBK,        8'h81,  1'b0, 1'b0, 2'd0, 8'h00,  8'h00},
    '{MODE_GBK,        CH_LF,  1'b0, 1'b1, 2'd2, 8'h81,  CH_LF},
    '{MODE_GBK,        8'hFE,  1'b0, 1'b0, 2'd0, 8'h00,  8'h00},
    '{MODE_GBK,        8'h41,  1'b0, 1'b1, 2'd2, 8'hFE,  8'h41},
    '{MODE_GBK,        8'h80,  1'b0, 1'b1, 2'd1, 8'h80,  8'h00},
    '{MODE_GBK,        8'hFF,  1'b0, 1'b1, 2'd1, 8'hFF,  8'h00},
    '{MODE_GBK,        8'hFE,  1'b1, 1'b0, 2'd0, 8'h00,  8'h00},
    '{MODE_UNDEFINED,  CH_LF,  1'b0, 1'b1, 2'd2, CH_CR,  CH_LF}
  };

  function automatic logic [31:0] bump(logic [31:0] v);
    return (v == '1) ? v : v + 32'd1;
  endfunction

  function automatic void clear_line_state();
    touched    = 1'b0;
    has_bytes  = 1'b0;
    after_cr   = 1'b0;
    scan_phase = GBK_FIRST;
    held_v     = 1'b0;
  endfunction

  function automatic void close_line();
    n_in  = bump(n_in);
    n_out = bump(n_out);
    if (touched) n_changed = bump(n_changed);
    clear_line_state();
  endfunction

  function automatic void model_set_mode(logic [1:0] m);
    cur_mode   = m;
    held_v     = 1'b0;
    after_cr   = 1'b0;
    scan_phase = GBK_FIRST;
  endfunction

  function automatic void convert_gbk(logic [7:0] b);
    logic [7:0] lead;
    if (b == CH_LF) begin
      if (held_v) step_bytes.push_back(held_b);
      step_bytes.push_back(CH_LF);
      close_line();
    end else begin
      has_bytes = 1'b1;
      if (scan_phase == GBK_LEAD) begin
        lead   = held_b;
        held_v = 1'b0;
        if (b >= GBK_DIGIT_LO && b <= GBK_DIGIT_HI) begin
          step_bytes.push_back(lead);
          step_bytes.push_back(b);
          scan_phase = GBK_REM2;
        end else if (lead == GBK_SPACE && b == GBK_SPACE) begin
          // A full-width space becomes a line break of its own.
          step_bytes.push_back(CH_CR);
          step_bytes.push_back(CH_LF);
          n_out      = bump(n_out);
          touched    = 1'b1;
          scan_phase = GBK_FIRST;
        end else begin
          step_bytes.push_back(lead);
          step_bytes.push_back(b);
          scan_phase = GBK_FIRST;
        end
      end else if (scan_phase == GBK_REM2) begin
        step_bytes.push_back(b);
        scan_phase = GBK_REM1;
      end else if (scan_phase == GBK_REM1) begin
        step_bytes.push_back(b);
        scan_phase = GBK_FIRST;
      end else if (b >= GBK_LEAD_LO && b <= GBK_LEAD_HI) begin
        held_v     = 1'b1;
        held_b     = b;
        scan_phase = GBK_LEAD;
      end else begin
        step_bytes.push_back(b);
      end
    end
  endfunction

  function automatic void convert_request(tlec_in_t req);
    logic [7:0] b;
    logic       cr_eaten;
    b        = req.in_byte;
    cr_eaten = 1'b0;
    step_bytes.delete();
    if (cur_mode == MODE_CRLF_TO_LF) begin
      if (held_v) begin
        held_v = 1'b0;
        if (b == CH_LF) begin
          step_bytes.push_back(CH_LF);
          touched = 1'b1;
          close_line();
          cr_eaten = 1'b1;
        end else begin
          step_bytes.push_back(CH_CR);
        end
      end
      if (!cr_eaten) begin
        if (b == CH_CR) begin
          held_v    = 1'b1;
          held_b    = CH_CR;
          has_bytes = 1'b1;
        end else if (b == CH_LF) begin
          step_bytes.push_back(CH_LF);
          close_line();
        end else begin
          step_bytes.push_back(b);
          has_bytes = 1'b1;
        end
      end
    end else if (cur_mode == MODE_GBK) begin
      convert_gbk(b);
    end else begin
      if (b == CH_LF) begin
        if (!after_cr) begin
          step_bytes.push_back(CH_CR);
          touched = 1'b1;
        end
        step_bytes.push_back(CH_LF);
        close_line();
      end else begin
        step_bytes.push_back(b);
        after_cr  = (b == CH_CR);
        has_bytes = 1'b1;
      end
    end
    if (req.end_of_stream) begin
      if (held_v) step_bytes.push_back(held_b);
      if (has_bytes) begin
        n_in  = bump(n_in);
        n_out = bump(n_out);
        if (touched) n_changed = bump(n_changed);
      end
      clear_line_state();
    end
  endfunction

  function automatic void queue_results();
    tlec_out_t res;
    for (int k = 0; k < step_bytes.size(); k++) begin
      res.out_byte      = step_bytes[k];
      res.out_last      = (k == step_bytes.size() - 1);
      res.lines_in      = n_in;
      res.lines_changed = n_changed;
      res.lines_out     = n_out;
      expected_text.push_back(res);
    end
  endfunction

  // Appends one short piece of text shaped for the given mode.
  function automatic void fill_text(logic [1:0] m);
    int r;
    r = $urandom_range(0, 11);
    if (m == MODE_CRLF_TO_LF) begin
      if (r <= 2) begin
        text_q.push_back(CH_CR);
        text_q.push_back(CH_LF);
      end else if (r == 3) begin
        text_q.push_back(CH_CR);
      end else if (r == 4) begin
        text_q.push_back(CH_LF);
      end else if (r == 5) begin
        text_q.push_back(CH_CR);
        text_q.push_back(CH_CR);
        text_q.push_back(CH_LF);
      end else begin
        text_q.push_back(8'($urandom_range(0, 255)));
      end
    end else if (m == MODE_GBK) begin
      if (r <= 1) begin
        text_q.push_back(GBK_SPACE);
        text_q.push_back(GBK_SPACE);
      end else if (r <= 3) begin
        text_q.push_back(8'($urandom_range(GBK_LEAD_LO, GBK_LEAD_HI)));
        text_q.push_back(8'($urandom_range(8'h40, GBK_LEAD_HI)));
      end else if (r == 4) begin
        text_q.push_back(8'($urandom_range(GBK_LEAD_LO, GBK_LEAD_HI)));
        text_q.push_back(8'($urandom_range(GBK_DIGIT_LO, GBK_DIGIT_HI)));
        text_q.push_back(8'($urandom_range(GBK_LEAD_LO, GBK_LEAD_HI)));
        text_q.push_back(8'($urandom_range(GBK_DIGIT_LO, GBK_DIGIT_HI)));
      end else if (r == 5) begin
        text_q.push_back(8'($urandom_range(8'h20, 8'h7E)));
      end else if (r == 6) begin
        text_q.push_back(CH_LF);
      end else if (r == 7) begin
        text_q.push_back(8'($urandom_range(GBK_LEAD_LO, GBK_LEAD_HI)));
        text_q.push_back(CH_LF);
      end else if (r == 8) begin
        text_q.push_back(8'($urandom_range(GBK_LEAD_LO, GBK_LEAD_HI)));
        text_q.push_back(8'($urandom_range(0, 255)));
      end else if (r == 9) begin
        text_q.push_back(($urandom_range(0, 1) == 0) ? 8'h80 : 8'hFF);
      end else begin
        text_q.push_back(8'($urandom_range(0, 255)));
      end
    end else begin
      if (r <= 1) begin
        text_q.push_back(CH_LF);
      end else if (r == 2) begin
        text_q.push_back(CH_CR);
        text_q.push_back(CH_LF);
      end else if (r == 3) begin
        text_q.push_back(CH_CR);
      end else if (r == 4) begin
        text_q.push_back(8'h00);
      end else begin
        text_q.push_back(8'($urandom_range(0, 255)));
      end
    end
  endfunction

  // Offers one request, waits for it to be taken, then records what it should produce.
  task automatic send_request(input tlec_in_t req, input logic typed, input logic [1:0] n,
                              input logic [7:0] e0, input logic [7:0] e1);
    if (!calm && $urandom_range(0, 4) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= req;
    do @(posedge clk); while (in_stall);
    requests_sent++;
    convert_request(req);
    if (typed) begin
      step_bytes.delete();
      if (n >= 2'd1) step_bytes.push_back(e0);
      if (n == 2'd2) step_bytes.push_back(e1);
    end
    queue_results();
  endtask

  // Mode writes happen only with nothing in flight; a held byte may still be inside.
  task automatic apply_mode(input logic [1:0] m);
    in_valid <= 1'b0;
    while (expected_text.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    cfg_we   <= 1'b1;
    cfg_data <= m;
    @(posedge clk);
    cfg_we <= 1'b0;
    model_set_mode(m);
  endtask

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    #2000000;
    $display("%0t: timeout with %0d results outstanding", $time, expected_text.size());
    $display("[FAIL] regression broken");
    $finish;
  end

  // Result side: checks every accepted result and stalls in random bursts.
  initial begin
    int  stall_left;
    bit  long_hold_done;
    logic nxt;
    tlec_out_t exp_res;
    stall_left     = 0;
    long_hold_done = 0;
    out_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (out_valid && !out_stall) begin
        results_seen++;
        if (expected_text.size() == 0) begin
          $display("%0t: unexpected result byte %h, got nothing expected", $time,
                   out_data.out_byte);
          errors++;
        end else begin
          exp_res = expected_text.pop_front();
          if (out_data !== exp_res) begin
            $display("%0t: mismatch expected byte %h last %b in %0d chg %0d out %0d, got byte %h last %b in %0d chg %0d out %0d",
                     $time, exp_res.out_byte, exp_res.out_last, exp_res.lines_in,
                     exp_res.lines_changed, exp_res.lines_out, out_data.out_byte,
                     out_data.out_last, out_data.lines_in, out_data.lines_changed,
                     out_data.lines_out);
            errors++;
          end
        end
      end
      nxt = 1'b0;
      // One long hold while the sender keeps offering, so the input backs up.
      if (!long_hold_done && results_seen >= LONG_HOLD_AT) begin
        long_hold_done = 1;
        stall_left     = LONG_HOLD_CYCLES;
      end else if (stall_left == 0 && !calm && $urandom_range(0, 5) == 0) begin
        stall_left = $urandom_range(1, 6);
      end
      if (stall_left > 0) begin
        nxt = 1'b1;
        stall_left--;
      end
      out_stall <= nxt;
    end
  end

  initial begin
    tlec_in_t   req;
    logic [1:0] phase_modes [8];
    phase_modes = '{MODE_GBK, MODE_LF_TO_CRLF, MODE_CRLF_TO_LF, MODE_GBK,
                    MODE_UNDEFINED, MODE_CRLF_TO_LF, MODE_GBK, MODE_LF_TO_CRLF};
    errors        = 0;
    requests_sent = 0;
    results_seen  = 0;
    calm          = 0;
    held_b        = 8'h00;
    n_in          = '0;
    n_changed     = '0;
    n_out         = '0;
    cur_mode      = MODE_LF_TO_CRLF;
    clear_line_state();
    rst_n    <= 1'b0;
    in_valid <= 1'b0;
    in_data  <= '0;
    cfg_we   <= 1'b0;
    cfg_data <= MODE_LF_TO_CRLF;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    apply_mode(MODE_LF_TO_CRLF);
    foreach (directed_rows[i]) begin
      if (directed_rows[i].mode != cur_mode) apply_mode(directed_rows[i].mode);
      req.in_byte       = directed_rows[i].data;
      req.end_of_stream = directed_rows[i].eos;
      send_request(req, directed_rows[i].typed, directed_rows[i].n,
                   directed_rows[i].e0, directed_rows[i].e1);
    end

    for (int p = 0; p < 8; p++) begin
      apply_mode(phase_modes[p]);
      calm = (p == 7);
      text_q.delete();
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        if (text_q.size() == 0) fill_text(phase_modes[p]);
        req.in_byte       = text_q.pop_front();
        req.end_of_stream = ($urandom_range(0, 59) == 0);
        send_request(req, 1'b0, 2'd0, 8'h00, 8'h00);
      end
    end

    in_valid <= 1'b0;
    for (int w = 0; w < 5000 && expected_text.size() != 0; w++) @(posedge clk);
    repeat (8) @(posedge clk);
    if (expected_text.size() != 0) begin
      $display("%0t: %0d expected results never arrived, next byte %h", $time,
               expected_text.size(), expected_text[0].out_byte);
      errors++;
    end

    $display("Covered %0d requests across all four mode settings, %0d results checked.",
             requests_sent, results_seen);
    $display("Model counters at end: %0d lines in, %0d changed, %0d out; %0d errors.",
             n_in, n_changed, n_out, errors);
    if (errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
+incdir+hw/rtl
hw/rtl/tlec_pkg.sv
hw/rtl/tlec_step.sv
hw/rtl/text_line_ending_converter.sv
test/tb.sv
